### sv/bdhr_pkg.sv
// Package for the button debouncer with long-press and auto-repeat.
// Holds action codes, register indexes and reset values; no dependencies.
package bdhr_pkg;

    localparam int PIN_BITS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 16;

    typedef enum logic [1:0] {
        ACT_TICK        = 2'd0,
        ACT_READ_PRESS  = 2'd1,
        ACT_READ_HOLD   = 2'd2,
        ACT_READ_REPEAT = 2'd3
    } action_t;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS = 2'd1;

    localparam logic [COUNT_W-1:0] HOLD_TICKS_RESET   = 16'd100;
    localparam logic [COUNT_W-1:0] REPEAT_TICKS_RESET = 16'd20;

endpackage

### sv/button_debounce_hold_repeat_top.sv
// Top level of the button debouncer with long-press and auto-repeat flags.
// Depends on bdhr_pkg for action codes, register indexes and reset values.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+------------------
//  input     | action, pin_levels, button_index          | in_valid/in_ready
//  output    | flag                                      | out_valid/out_ready
//  config    | cfg_index, cfg_wdata                      | cfg_we, no wait
//
// One item per cycle sustained while results are taken. An accepted item sits in the
// input register, and its result loads into the result register once that one is free.
// Per-button update logic sits between the input register and the result register.
// Reset sets all buttons released, counters and flags zero, registers to 100 and 20.
// When both registers hold items and the result is not taken, in_ready drops until it is.
module button_debounce_hold_repeat_top #(
    parameter int BUTTONS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       action,
    input  logic [bdhr_pkg::PIN_BITS-1:0]    pin_levels,
    input  logic [1:0]                       button_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             flag,
    input  logic                             cfg_we,
    input  logic [bdhr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdhr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = bdhr_pkg::COUNT_W;

    logic [CW-1:0] hold_ticks_reg;
    logic [CW-1:0] repeat_ticks_reg;

    // input register
    logic                          item_valid_reg;
    bdhr_pkg::action_t             action_reg;
    logic [bdhr_pkg::PIN_BITS-1:0] pins_reg;
    logic [1:0]                    index_reg;

    // result register
    logic out_valid_reg;
    logic flag_reg;
    logic flag_next;

    // per-button state
    logic [BUTTONS-1:0] sample_oldest_reg, sample_oldest_next;
    logic [BUTTONS-1:0] sample_middle_reg, sample_middle_next;
    logic [BUTTONS-1:0] sample_newest_reg, sample_newest_next;
    logic [BUTTONS-1:0] stable_level_reg, stable_level_next;
    logic [BUTTONS-1:0] short_press_reg, short_press_next;
    logic [BUTTONS-1:0] long_hold_reg, long_hold_next;
    logic [BUTTONS-1:0] fast_repeat_reg, fast_repeat_next;
    logic [CW-1:0]      hold_count_reg [BUTTONS];
    logic [CW-1:0]      hold_count_next [BUTTONS];
    logic [CW-1:0]      repeat_phase_reg [BUTTONS];
    logic [CW-1:0]      repeat_phase_next [BUTTONS];

    logic [BUTTONS-1:0] level;
    logic               advance;
    logic               process;
    logic [CW:0]        cap_wide;
    logic [CW-1:0]      hold_cap;

    assign advance   = !out_valid_reg || out_ready;
    assign process   = item_valid_reg && advance;
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign flag      = flag_reg;

    // buttons beyond the pin field read as released
    genvar g;
    generate
        for (g = 0; g < BUTTONS; g++) begin : g_level
            if (g < bdhr_pkg::PIN_BITS) begin : g_pin
                assign level[g] = pins_reg[g];
            end else begin : g_none
                assign level[g] = 1'b1;
            end
        end
    endgenerate

    // hold count stops at hold_ticks + 1, clamped to the counter's full scale
    assign cap_wide = {1'b0, hold_ticks_reg} + {{CW{1'b0}}, 1'b1};
    assign hold_cap = cap_wide[CW] ? {CW{1'b1}} : cap_wide[CW-1:0];

    always_comb
    begin
        logic [CW-1:0] phase_inc;
        logic          agree;
        sample_oldest_next = sample_oldest_reg;
        sample_middle_next = sample_middle_reg;
        sample_newest_next = sample_newest_reg;
        stable_level_next  = stable_level_reg;
        short_press_next   = short_press_reg;
        long_hold_next     = long_hold_reg;
        fast_repeat_next   = fast_repeat_reg;
        hold_count_next    = hold_count_reg;
        repeat_phase_next  = repeat_phase_reg;
        flag_next          = flag_reg;
        phase_inc          = '0;
        agree              = 1'b0;

        if (process) begin
            flag_next = 1'b0;
            for (int b = 0; b < BUTTONS; b++) begin
                if (action_reg == bdhr_pkg::ACT_TICK) begin
                    sample_oldest_next[b] = sample_middle_reg[b];
                    sample_middle_next[b] = sample_newest_reg[b];
                    sample_newest_next[b] = level[b];
                    agree = (sample_middle_reg[b] == sample_newest_reg[b])
                         && (sample_newest_reg[b] == level[b]);
                    phase_inc = repeat_phase_reg[b] + {{(CW-1){1'b0}}, 1'b1};
                    if (agree) begin
                        if (stable_level_reg[b] != level[b]) begin
                            stable_level_next[b] = level[b];
                            if (!level[b]) begin
                                hold_count_next[b]   = '0;
                                repeat_phase_next[b] = '0;
                            end else begin
                                if (hold_count_reg[b] < hold_ticks_reg) begin
                                    short_press_next[b] = 1'b1;
                                end
                                long_hold_next[b]   = 1'b0;
                                fast_repeat_next[b] = 1'b0;
                            end
                        end else if (!level[b]) begin
                            if (hold_count_reg[b] < hold_ticks_reg) begin
                                if (hold_count_reg[b] + {{(CW-1){1'b0}}, 1'b1}
                                        == hold_ticks_reg) begin
                                    long_hold_next[b]    = 1'b1;
                                    repeat_phase_next[b] = '0;
                                end
                            end else if (phase_inc == repeat_ticks_reg) begin
                                fast_repeat_next[b]  = 1'b1;
                                repeat_phase_next[b] = '0;
                            end else begin
                                repeat_phase_next[b] = phase_inc;
                            end
                            if (hold_count_reg[b] < hold_cap) begin
                                hold_count_next[b] = hold_count_reg[b]
                                                   + {{(CW-1){1'b0}}, 1'b1};
                            end
                        end
                    end
                end else if (int'(index_reg) == b) begin
                    // return the flag and clear it
                    case (action_reg)
                        bdhr_pkg::ACT_READ_PRESS:
                        begin
                            flag_next           = short_press_reg[b];
                            short_press_next[b] = 1'b0;
                        end
                        bdhr_pkg::ACT_READ_HOLD:
                        begin
                            flag_next         = long_hold_reg[b];
                            long_hold_next[b] = 1'b0;
                        end
                        bdhr_pkg::ACT_READ_REPEAT:
                        begin
                            flag_next           = fast_repeat_reg[b];
                            fast_repeat_next[b] = 1'b0;
                        end
                        default:
                        begin
                            flag_next = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_ticks_reg    <= bdhr_pkg::HOLD_TICKS_RESET;
            repeat_ticks_reg  <= bdhr_pkg::REPEAT_TICKS_RESET;
            item_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            sample_oldest_reg <= '1;
            sample_middle_reg <= '1;
            sample_newest_reg <= '1;
            stable_level_reg  <= '1;
            short_press_reg   <= '0;
            long_hold_reg     <= '0;
            fast_repeat_reg   <= '0;
            for (int b = 0; b < BUTTONS; b++) begin
                hold_count_reg[b]   <= '0;
                repeat_phase_reg[b] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bdhr_pkg::REG_HOLD_TICKS:   hold_ticks_reg   <= cfg_wdata;
                    bdhr_pkg::REG_REPEAT_TICKS: repeat_ticks_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= item_valid_reg;
            end
            sample_oldest_reg <= sample_oldest_next;
            sample_middle_reg <= sample_middle_next;
            sample_newest_reg <= sample_newest_next;
            stable_level_reg  <= stable_level_next;
            short_press_reg   <= short_press_next;
            long_hold_reg     <= long_hold_next;
            fast_repeat_reg   <= fast_repeat_next;
            hold_count_reg    <= hold_count_next;
            repeat_phase_reg  <= repeat_phase_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            action_reg <= bdhr_pkg::action_t'(action);
            pins_reg   <= pin_levels;
            index_reg  <= button_index;
        end
        flag_reg <= flag_next;
    end

endmodule

### sv/bdhr_checker.sv
// Port-level checker for button_debounce_hold_repeat_top, bound to the top level.
// Depends on the top level's port list only.
module bdhr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic flag
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(flag))
        else $error("result changed while stalled");

    // input stalls only behind a full, untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a taken result frees room for the next item
    a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input not ready while result is taken");

    // a result leaves only when taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result dropped without being taken");

endmodule

bind button_debounce_hold_repeat_top bdhr_checker u_bdhr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flag      (flag)
);

### tb/button_debounce_hold_repeat_top_tb.sv
// Testbench for button_debounce_hold_repeat_top: directed and random items,
// with flags checked against a debounce predictor. Depends on bdhr_pkg.
module button_debounce_hold_repeat_top_tb;

    localparam int BUTTON_COUNT = 4;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 8;
    localparam logic PRESSED    = 1'b0;
    localparam logic RELEASED   = 1'b1;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [1:0]                      action;
    logic [bdhr_pkg::PIN_BITS-1:0]   pin_levels;
    logic [1:0]                      button_index;
    logic                            out_valid;
    logic                            out_ready;
    logic                            flag;
    logic                            cfg_we;
    logic [bdhr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bdhr_pkg::CFG_DATA_W-1:0] cfg_wdata;

    button_debounce_hold_repeat_top #(
        .BUTTONS(BUTTON_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .pin_levels(pin_levels),
        .button_index(button_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .flag(flag),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Predictor state
    logic [bdhr_pkg::COUNT_W-1:0] hold_limit;
    logic [bdhr_pkg::COUNT_W-1:0] repeat_limit;
    logic [BUTTON_COUNT-1:0]      hist_old;
    logic [BUTTON_COUNT-1:0]      hist_mid;
    logic [BUTTON_COUNT-1:0]      hist_new;
    logic [BUTTON_COUNT-1:0]      stable_lvl;
    logic [BUTTON_COUNT-1:0]      short_pend;
    logic [BUTTON_COUNT-1:0]      hold_pend;
    logic [BUTTON_COUNT-1:0]      repeat_pend;
    logic [bdhr_pkg::COUNT_W-1:0] hold_cnt [BUTTON_COUNT];
    logic [bdhr_pkg::COUNT_W-1:0] rep_phase [BUTTON_COUNT];

    logic                          pending_flags [$];
    logic [bdhr_pkg::PIN_BITS-1:0] held_pins;
    bit                            quiet_input;
    int                            fail_count;
    int                            idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic reset_predictor();
        hold_limit   = bdhr_pkg::HOLD_TICKS_RESET;
        repeat_limit = bdhr_pkg::REPEAT_TICKS_RESET;
        hist_old     = '1;
        hist_mid     = '1;
        hist_new     = '1;
        stable_lvl   = '1;
        short_pend   = '0;
        hold_pend    = '0;
        repeat_pend  = '0;
        for (int b = 0; b < BUTTON_COUNT; b++)
        begin
            hold_cnt[b]  = '0;
            rep_phase[b] = '0;
        end
    endtask

    // Advance the debounce state by one item and return the flag it yields
    function automatic logic predict_flag(bdhr_pkg::action_t act,
                                          logic [bdhr_pkg::PIN_BITS-1:0] pins,
                                          logic [1:0] idx);
        logic        result;
        logic        lvl;
        logic [16:0] cnt;
        logic [16:0] cap;
        result = 1'b0;
        if (act == bdhr_pkg::ACT_TICK)
        begin
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                lvl = (b < bdhr_pkg::PIN_BITS) ? pins[b] : RELEASED;
                hist_old[b] = hist_mid[b];
                hist_mid[b] = hist_new[b];
                hist_new[b] = lvl;
                if (hist_old[b] == hist_mid[b] && hist_mid[b] == hist_new[b])
                begin
                    if (stable_lvl[b] != lvl)
                    begin
                        stable_lvl[b] = lvl;
                        if (lvl == PRESSED)
                        begin
                            hold_cnt[b]  = '0;
                            rep_phase[b] = '0;
                        end
                        else
                        begin
                            if (hold_cnt[b] < hold_limit)
                                short_pend[b] = 1'b1;
                            hold_pend[b]   = 1'b0;
                            repeat_pend[b] = 1'b0;
                        end
                    end
                    else if (lvl == PRESSED)
                    begin
                        cnt = {1'b0, hold_cnt[b]};
                        cap = {1'b0, hold_limit} + 17'd1;
                        if (cap > 17'h0FFFF)
                            cap = 17'h0FFFF;
                        if (cnt < {1'b0, hold_limit})
                        begin
                            if (cnt + 17'd1 == {1'b0, hold_limit})
                            begin
                                hold_pend[b] = 1'b1;
                                rep_phase[b] = '0;
                            end
                        end
                        else
                        begin
                            // phase wraps at 16 bits, so a zero interval acts as 65536
                            rep_phase[b] = rep_phase[b] + 16'd1;
                            if (rep_phase[b] == repeat_limit)
                            begin
                                repeat_pend[b] = 1'b1;
                                rep_phase[b]   = '0;
                            end
                        end
                        if (cnt < cap)
                            cnt = cnt + 17'd1;
                        hold_cnt[b] = cnt[15:0];
                    end
                end
            end
        end
        else if (idx < BUTTON_COUNT)
        begin
            case (act)
                bdhr_pkg::ACT_READ_PRESS:
                begin
                    result          = short_pend[idx];
                    short_pend[idx] = 1'b0;
                end
                bdhr_pkg::ACT_READ_HOLD:
                begin
                    result         = hold_pend[idx];
                    hold_pend[idx] = 1'b0;
                end
                default:
                begin
                    result           = repeat_pend[idx];
                    repeat_pend[idx] = 1'b0;
                end
            endcase
        end
        return result;
    endfunction

    function automatic void note_failure(string what, logic exp_val, logic got_val);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected %0b, got %0b at %0t", what, exp_val, got_val, $realtime);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_input)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(bdhr_pkg::action_t act, logic [bdhr_pkg::PIN_BITS-1:0] pins,
                             logic [1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        pin_levels   <= pins;
        button_index <= idx;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        pending_flags.push_back(predict_flag(act, pins, idx));
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected flag has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [bdhr_pkg::CFG_IDX_W-1:0] idx,
                             logic [bdhr_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == bdhr_pkg::REG_HOLD_TICKS)
            hold_limit = val;
        else if (idx == bdhr_pkg::REG_REPEAT_TICKS)
            repeat_limit = val;
        @(negedge clk);
    endtask

    task automatic set_timing(logic [bdhr_pkg::CFG_DATA_W-1:0] hold_val,
                              logic [bdhr_pkg::CFG_DATA_W-1:0] rep_val);
        settle();
        write_reg(bdhr_pkg::REG_HOLD_TICKS, hold_val);
        write_reg(bdhr_pkg::REG_REPEAT_TICKS, rep_val);
    endtask

    // Mostly clean press/release sequences with rare glitches, plus noise items
    task automatic run_random(int count, int flip_odds);
        int                            r;
        int                            bit_sel;
        logic [bdhr_pkg::PIN_BITS-1:0] pins;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                quiet_input = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 8)
                send_item(bdhr_pkg::action_t'($urandom_range(0, 3)), 4'($urandom),
                          2'($urandom));
            else if (r < 62)
            begin
                for (int b = 0; b < bdhr_pkg::PIN_BITS; b++)
                    if ($urandom_range(0, flip_odds - 1) == 0)
                        held_pins[b] = ~held_pins[b];
                pins = held_pins;
                if ($urandom_range(0, 7) == 0)
                begin
                    bit_sel = $urandom_range(0, bdhr_pkg::PIN_BITS - 1);
                    pins[bit_sel] = ~pins[bit_sel];
                end
                send_item(bdhr_pkg::ACT_TICK, pins, 2'($urandom));
            end
            else
                send_item(bdhr_pkg::action_t'($urandom_range(1, 3)), 4'($urandom),
                          2'($urandom_range(0, 3)));
        end
        quiet_input = 1'b0;
    endtask

    task automatic test_reset_flags();
        send_item(bdhr_pkg::ACT_READ_HOLD, 4'hF, 2'd3);
        send_item(bdhr_pkg::ACT_READ_REPEAT, 4'hF, 2'd2);
        // press all, then release well short of the hold count
        repeat (3) send_item(bdhr_pkg::ACT_TICK, 4'h0, 2'd0);
        repeat (3) send_item(bdhr_pkg::ACT_TICK, 4'hF, 2'd0);
        send_item(bdhr_pkg::ACT_READ_PRESS, 4'hF, 2'd0);
        send_item(bdhr_pkg::ACT_READ_PRESS, 4'hF, 2'd3);
        send_item(bdhr_pkg::ACT_READ_PRESS, 4'hF, 2'd0);
    endtask

    task automatic test_debounce_glitch();
        send_item(bdhr_pkg::ACT_TICK, 4'hA, 2'd0);
        send_item(bdhr_pkg::ACT_TICK, 4'h5, 2'd0);
        send_item(bdhr_pkg::ACT_TICK, 4'hA, 2'd0);
        send_item(bdhr_pkg::ACT_READ_PRESS, 4'h0, 2'd1);
        send_item(bdhr_pkg::ACT_READ_HOLD, 4'h0, 2'd2);
    endtask

    task automatic test_hold_repeat();
        set_timing(16'd1, 16'd1);
        // press start, hold flag, repeat, then repeat on a saturated count
        repeat (6) send_item(bdhr_pkg::ACT_TICK, 4'hE, 2'd0);
        send_item(bdhr_pkg::ACT_READ_HOLD, 4'hE, 2'd0);
        send_item(bdhr_pkg::ACT_READ_REPEAT, 4'hE, 2'd0);
    endtask

    task automatic test_ignored_registers();
        set_timing(16'd4, 16'd2);
        write_reg(2'd2, 16'($urandom));
        write_reg(2'd3, 16'($urandom));
        run_random(60, 10);
    endtask

    task automatic test_random_settings();
        logic [bdhr_pkg::CFG_DATA_W-1:0] hold_set [9];
        logic [bdhr_pkg::CFG_DATA_W-1:0] rep_set [9];
        hold_set = '{16'd1, 16'd0, 16'd5, 16'd3, 16'd65535, 16'd2, 16'd0, 16'd100, 16'd0};
        rep_set  = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd65535, 16'd65535, 16'd0, 16'd20, 16'd0};
        hold_set[8] = 16'($urandom_range(1, 10));
        rep_set[8]  = 16'($urandom_range(1, 5));
        for (int s = 0; s < 9; s++)
        begin
            // buttons stay held across the write, so new timing lands mid-press
            set_timing(hold_set[s], rep_set[s]);
            run_random(65, $urandom_range(6, 16));
        end
    endtask

    // Result side: accept with random stalls, some windows without any
    initial
    begin
        int stall_left;
        int win_left;
        int r;
        bit no_stall;
        stall_left = 0;
        win_left   = 0;
        no_stall   = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (win_left == 0)
            begin
                no_stall = ($urandom_range(0, 3) == 0);
                win_left = 64;
            end
            win_left--;
            if (no_stall)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    out_ready <= 1'b1;
                else if (r < 95)
                begin
                    stall_left = $urandom_range(0, 2);
                    out_ready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(8, 25);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_flags.size() == 0)
                note_failure("unexpected result", 1'bx, flag);
            else if (flag !== pending_flags[0])
            begin
                note_failure("flag mismatch", pending_flags[0], flag);
                void'(pending_flags.pop_front());
            end
            else
                void'(pending_flags.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("button_debounce_hold_repeat_top test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = bdhr_pkg::ACT_TICK;
        pin_levels   = '1;
        button_index = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        held_pins    = '1;
        quiet_input  = 1'b0;
        fail_count   = 0;
        idle_cycles  = 0;
        reset_predictor();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_flags();
        test_debounce_glitch();
        test_hold_repeat();
        test_ignored_registers();
        test_random_settings();

        settle();
        if (pending_flags.size() != 0)
            note_failure("missing result", pending_flags[0], 1'bx);
        if (fail_count == 0)
            $display("button_debounce_hold_repeat_top test passed");
        else
            $display("button_debounce_hold_repeat_top test failed");
        $finish;
    end

endmodule
